// ===== rtl/spmt_pkg.sv =====
`timescale 1ns / 1ps

package spmt_pkg;

   // default store depth and fixed field widths
   localparam int MAX_AXES_DEF = 6;
   localparam int IDX_W        = 48;
   localparam int REST_W       = IDX_W + 1;
   localparam int AXIS_W       = 31;
   localparam int SEL_W        = 3;
   localparam int CNT_W        = 3;
   localparam int DIV_STEPS    = IDX_W;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_CHECK,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic div_start;
      logic advance;
      logic set_verdict;
      logic verdict;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_load;
      logic rest_neg;
      logic rest_zero;
      logic axis_zero;
      logic step_zero;
      logic div_done;
      logic quot_ok;
   } status_type;

endpackage

// ===== rtl/spmt_div.sv =====
`timescale 1ns / 1ps

module spmt_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [spmt_pkg::IDX_W-1:0]      dividend,
   input  logic [spmt_pkg::AXIS_W-1:0]     divisor,
   output logic                            done,
   output logic [spmt_pkg::IDX_W-1:0]      quotient,
   output logic [spmt_pkg::AXIS_W-1:0]     remainder
);

   // restoring divider, one quotient bit per cycle
   logic                              run_ff, run_in;
   logic                              done_ff, done_in;
   logic [spmt_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [spmt_pkg::IDX_W-1:0]        dq_ff, dq_in;
   logic [spmt_pkg::AXIS_W-1:0]       rem_ff, rem_in;
   logic [spmt_pkg::AXIS_W-1:0]       dvs_ff, dvs_in;

   logic [spmt_pkg::AXIS_W:0]         r_try;
   logic [spmt_pkg::AXIS_W+1:0]       diff;
   logic                              ge;

   always_comb begin
      r_try = {rem_ff, dq_ff[spmt_pkg::IDX_W-1]};
      diff  = {1'b0, r_try} - {2'b00, dvs_ff};
      ge    = ~diff[spmt_pkg::AXIS_W+1];
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         dq_in  = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (run_ff) begin
         dq_in  = {dq_ff[spmt_pkg::IDX_W-2:0], ge};
         rem_in = ge ? diff[spmt_pkg::AXIS_W-1:0] : r_try[spmt_pkg::AXIS_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == spmt_pkg::DIV_CNT_W'(spmt_pkg::DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = dq_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/spmt_dp.sv =====
`timescale 1ns / 1ps

module spmt_dp #(
   parameter int MAX_AXES = spmt_pkg::MAX_AXES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  spmt_pkg::cmd_type                   cmd,
   output spmt_pkg::status_type                status,
   input  logic                                req_op,
   input  logic [spmt_pkg::SEL_W-1:0]          req_axis_select,
   input  logic [spmt_pkg::AXIS_W-1:0]         req_axis_size,
   input  logic [spmt_pkg::AXIS_W-1:0]         req_axis_step,
   input  logic signed [spmt_pkg::IDX_W-1:0]   req_pattern_offset,
   input  logic [spmt_pkg::CNT_W-1:0]          req_axis_count,
   input  logic signed [spmt_pkg::IDX_W-1:0]   req_query_index,
   output logic                                rsp_is_member,
   output logic                                rsp_was_query
);

   localparam int AXW = $clog2(MAX_AXES + 1);
   localparam int IXW = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;

   logic [spmt_pkg::AXIS_W-1:0]      size_ff [MAX_AXES];
   logic [spmt_pkg::AXIS_W-1:0]      step_ff [MAX_AXES];

   logic signed [spmt_pkg::REST_W-1:0] rest_ff, rest_in;
   logic [AXW-1:0]                   axis_ff, axis_in;
   logic                             member_ff, member_in;
   logic                             query_ff, query_in;

   logic [AXW-1:0]                   axis_m1;
   logic [IXW-1:0]                   rd_idx;
   logic [spmt_pkg::AXIS_W-1:0]      size_rd;
   logic [spmt_pkg::AXIS_W-1:0]      step_rd;
   logic                             wr_en;

   logic                             div_done;
   logic [spmt_pkg::IDX_W-1:0]       quot;
   logic [spmt_pkg::AXIS_W-1:0]      remd;

   assign axis_m1 = axis_ff - 1'b1;
   assign rd_idx  = axis_m1[IXW-1:0];
   assign size_rd = size_ff[rd_idx];
   assign step_rd = step_ff[rd_idx];
   assign wr_en   = cmd.capture && (req_op == spmt_pkg::OP_LOAD)
                    && (32'(req_axis_select) < 32'(MAX_AXES));

   spmt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (rest_ff[spmt_pkg::IDX_W-1:0]),
      .divisor   (step_rd),
      .done      (div_done),
      .quotient  (quot),
      .remainder (remd)
   );

   always_comb begin
      rest_in   = rest_ff;
      axis_in   = axis_ff;
      member_in = member_ff;
      query_in  = query_ff;
      if (cmd.capture) begin
         member_in = 1'b0;
         query_in  = (req_op == spmt_pkg::OP_QUERY);
         rest_in   = spmt_pkg::REST_W'(req_query_index)
                     - spmt_pkg::REST_W'(req_pattern_offset);
         axis_in   = (32'(req_axis_count) > 32'(MAX_AXES)) ? AXW'(MAX_AXES)
                                                           : AXW'(req_axis_count);
      end else if (cmd.advance) begin
         rest_in = spmt_pkg::REST_W'(remd);
         axis_in = axis_m1;
      end
      if (cmd.set_verdict) begin
         member_in = cmd.verdict;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff   <= rest_in;
      axis_ff   <= axis_in;
      member_ff <= member_in;
      query_ff  <= query_in;
      if (wr_en) begin
         size_ff[req_axis_select[IXW-1:0]] <= req_axis_size;
         step_ff[req_axis_select[IXW-1:0]] <= req_axis_step;
      end
   end

   always_comb begin
      status.is_load   = (req_op == spmt_pkg::OP_LOAD);
      status.rest_neg  = rest_ff[spmt_pkg::REST_W-1];
      status.rest_zero = (rest_ff == '0);
      status.axis_zero = (axis_ff == '0);
      status.step_zero = (step_rd == '0);
      status.div_done  = div_done;
      status.quot_ok   = (quot[spmt_pkg::IDX_W-1:spmt_pkg::AXIS_W] == '0)
                         && (quot[spmt_pkg::AXIS_W-1:0] < size_rd);
   end

   assign rsp_is_member = member_ff;
   assign rsp_was_query = query_ff;

endmodule

// ===== rtl/spmt_ctrl.sv =====
`timescale 1ns / 1ps

module spmt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  spmt_pkg::status_type  status,
   output spmt_pkg::cmd_type     cmd,
   output logic                  busy,
   output logic                  rsp_valid
);

   spmt_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spmt_pkg::ST_IDLE: begin
            if (start) begin
               state_in = status.is_load ? spmt_pkg::ST_RESP : spmt_pkg::ST_SETUP;
            end
         end
         spmt_pkg::ST_SETUP: begin
            if (status.rest_neg || status.axis_zero || status.step_zero) begin
               state_in = spmt_pkg::ST_RESP;
            end else begin
               state_in = spmt_pkg::ST_DIV;
            end
         end
         spmt_pkg::ST_DIV: begin
            if (status.div_done) begin
               state_in = spmt_pkg::ST_CHECK;
            end
         end
         spmt_pkg::ST_CHECK: begin
            state_in = status.quot_ok ? spmt_pkg::ST_SETUP : spmt_pkg::ST_RESP;
         end
         spmt_pkg::ST_RESP: begin
            state_in = spmt_pkg::ST_IDLE;
         end
         default: begin
            state_in = spmt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         spmt_pkg::ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         spmt_pkg::ST_SETUP: begin
            // negative rest can never reach zero
            if (status.rest_neg) begin
               cmd.set_verdict = 1'b1;
               cmd.verdict     = 1'b0;
            end else if (status.axis_zero) begin
               cmd.set_verdict = 1'b1;
               cmd.verdict     = status.rest_zero;
            end else if (status.step_zero) begin
               cmd.set_verdict = 1'b1;
               cmd.verdict     = 1'b0;
            end else begin
               cmd.div_start = 1'b1;
            end
         end
         spmt_pkg::ST_DIV: begin
            cmd = '0;
         end
         spmt_pkg::ST_CHECK: begin
            if (status.quot_ok) begin
               cmd.advance = 1'b1;
            end else begin
               cmd.set_verdict = 1'b1;
               cmd.verdict     = 1'b0;
            end
         end
         spmt_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spmt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/strided_pattern_membership_test_top.sv =====
`timescale 1ns / 1ps

// strided pattern membership test. a beat is taken when start is high and busy
// is low; every beat yields exactly one result, shown for a single cycle with
// rsp_valid high, and the receiver cannot stall it, so it must sample on that
// edge. a load beat (req_op 0) writes size and stride of one axis, if the select
// is within the store depth, and is acknowledged in the cycle right after
// acceptance with rsp_was_query 0. a query beat walks the axes from the top
// down until the walk ends, and each axis passes through setup, the shared
// bit-serial divider with its done flag, and the range check; a failed range
// check ends the walk at once.
// a query that reads an axis never loaded gives an undefined answer.
module strided_pattern_membership_test_top #(
   parameter int MAX_AXES = spmt_pkg::MAX_AXES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request beat
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_op,
   input  logic [spmt_pkg::SEL_W-1:0]          req_axis_select,
   input  logic [spmt_pkg::AXIS_W-1:0]         req_axis_size,
   input  logic [spmt_pkg::AXIS_W-1:0]         req_axis_step,
   input  logic signed [spmt_pkg::IDX_W-1:0]   req_pattern_offset,
   input  logic [spmt_pkg::CNT_W-1:0]          req_axis_count,
   input  logic signed [spmt_pkg::IDX_W-1:0]   req_query_index,
   // response beat
   output logic                                rsp_valid,
   output logic                                rsp_is_member,
   output logic                                rsp_was_query
);

   // command and status between sequencer and datapath
   spmt_pkg::cmd_type    cmd;
   spmt_pkg::status_type status;

   // sequencer: walks axes from the top down, one division each
   spmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // datapath: axis store, running remainder, divider, verdict
   spmt_dp #(
      .MAX_AXES (MAX_AXES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_op             (req_op),
      .req_axis_select    (req_axis_select),
      .req_axis_size      (req_axis_size),
      .req_axis_step      (req_axis_step),
      .req_pattern_offset (req_pattern_offset),
      .req_axis_count     (req_axis_count),
      .req_query_index    (req_query_index),
      .rsp_is_member      (rsp_is_member),
      .rsp_was_query      (rsp_was_query)
   );

endmodule

// ===== rtl/spmt_chk.sv =====
`timescale 1ns / 1ps

module spmt_chk (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_is_member,
   input logic rsp_was_query
);

   // an accepted beat makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   // a result only comes while the item is still in flight
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown while idle");

   // one result per item, then ready again
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe longer than one cycle");

   // a load acknowledge never claims membership
   a_load_ack: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_was_query) |-> !rsp_is_member)
      else $error("load acknowledge with membership set");

endmodule

bind strided_pattern_membership_test_top spmt_chk u_chk (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

   // store depth as the block is built by default
   localparam int N_AXES = spmt_pkg::MAX_AXES_DEF;

   // run shape
   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 475;
   localparam int TOTAL_ITEMS   = DIRECTED_ROWS + RANDOM_ITEMS;
   localparam int SPLIT_A       = DIRECTED_ROWS + RANDOM_ITEMS / 3;
   localparam int SPLIT_B       = DIRECTED_ROWS + (2 * RANDOM_ITEMS) / 3;
   localparam int MAX_GAP       = 40;
   localparam int MAX_REPORTS   = 10;
   localparam int TAIL_CYCLES   = 16;
   // watchdog limit, well above a six-axis query plus the longest sender gap
   localparam int STALL_LIMIT   = 2000;

   // extremes of the fields
   localparam longint IDX_MAX_L  = 64'sd140737488355327;
   localparam longint IDX_MIN_L  = -64'sd140737488355328;
   localparam longint AXIS_MAX_L = 64'sd2147483647;

   // one request beat, all fields driven even where the op ignores them
   typedef struct {
      logic                              op;
      logic [spmt_pkg::SEL_W-1:0]        sel;
      logic [spmt_pkg::AXIS_W-1:0]       size;
      logic [spmt_pkg::AXIS_W-1:0]       step;
      logic signed [spmt_pkg::IDX_W-1:0] off;
      logic [spmt_pkg::CNT_W-1:0]        cnt;
      logic signed [spmt_pkg::IDX_W-1:0] idx;
   } spmt_beat_type;

   // one expected result beat
   typedef struct {
      logic is_member;
      logic was_query;
   } verdict_type;

   // directed row: the beat, and a typed answer where it is obvious
   typedef struct {
      spmt_beat_type beat;
      bit            typed;
      bit            member;
   } dir_row_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic                              req_op;
   logic [spmt_pkg::SEL_W-1:0]        req_axis_select;
   logic [spmt_pkg::AXIS_W-1:0]       req_axis_size;
   logic [spmt_pkg::AXIS_W-1:0]       req_axis_step;
   logic signed [spmt_pkg::IDX_W-1:0] req_pattern_offset;
   logic [spmt_pkg::CNT_W-1:0]        req_axis_count;
   logic signed [spmt_pkg::IDX_W-1:0] req_query_index;
   logic                              rsp_valid;
   logic                              rsp_is_member;
   logic                              rsp_was_query;

   // our own copy of the axis store, zero until loaded
   bit [spmt_pkg::AXIS_W-1:0] size_tbl [N_AXES];
   bit [spmt_pkg::AXIS_W-1:0] step_tbl [N_AXES];

   // answers still owed by the block, oldest first
   verdict_type verdict_q [$];

   // directed stimulus table
   dir_row_type dir_tab [$];

   int beats_sent   = 0;
   int load_beats   = 0;
   int query_beats  = 0;
   int members_seen = 0;
   int rsp_count    = 0;
   int mismatches   = 0;

   strided_pattern_membership_test_top dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_axis_select    (req_axis_select),
      .req_axis_size      (req_axis_size),
      .req_axis_step      (req_axis_step),
      .req_pattern_offset (req_pattern_offset),
      .req_axis_count     (req_axis_count),
      .req_query_index    (req_query_index),
      .rsp_valid          (rsp_valid),
      .rsp_is_member      (rsp_is_member),
      .rsp_was_query      (rsp_was_query)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // walk the axes from the top down: divide, range check, take off quot * stride
   function automatic bit member_of_pattern(logic signed [spmt_pkg::IDX_W-1:0] off,
                                            logic [spmt_pkg::CNT_W-1:0] cnt,
                                            logic signed [spmt_pkg::IDX_W-1:0] idx);
      longint rest;
      longint stride;
      longint extent;
      longint quot;
      int     used;
      rest = longint'(idx) - longint'(off);
      // axis count saturates at the store depth
      used = (cnt > N_AXES) ? N_AXES : int'(cnt);
      for (int a = used - 1; a >= 0; a--) begin
         stride = longint'(step_tbl[a]);
         extent = longint'(size_tbl[a]);
         // zero stride rejects outright
         if (stride == 0) return 1'b0;
         // signed division truncates toward zero, so a small negative rest gives 0
         quot = rest / stride;
         if (quot < 0 || quot >= extent) return 1'b0;
         rest -= quot * stride;
      end
      return rest == 0;
   endfunction

   function automatic logic [spmt_pkg::IDX_W-1:0] rand48();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[spmt_pkg::IDX_W-1:0];
   endfunction

   function automatic logic [spmt_pkg::AXIS_W-1:0] rand31();
      logic [31:0] w;
      w = $urandom;
      return w[spmt_pkg::AXIS_W-1:0];
   endfunction

   // fully random beat, fields the op ignores carry noise
   function automatic spmt_beat_type rand_beat();
      spmt_beat_type b;
      b.op   = 1'($urandom_range(1));
      b.sel  = spmt_pkg::SEL_W'($urandom_range(7));
      b.size = rand31();
      b.step = rand31();
      b.off  = rand48();
      b.cnt  = spmt_pkg::CNT_W'($urandom_range(7));
      b.idx  = rand48();
      return b;
   endfunction

   function automatic dir_row_type mk(logic op, int sel, longint size, longint step,
                                      longint off, int cnt, longint idx,
                                      bit typed, bit member);
      dir_row_type r;
      r.beat.op   = op;
      r.beat.sel  = spmt_pkg::SEL_W'(sel);
      r.beat.size = spmt_pkg::AXIS_W'(size);
      r.beat.step = spmt_pkg::AXIS_W'(step);
      r.beat.off  = spmt_pkg::IDX_W'(off);
      r.beat.cnt  = spmt_pkg::CNT_W'(cnt);
      r.beat.idx  = spmt_pkg::IDX_W'(idx);
      r.typed     = typed;
      r.member    = member;
      return r;
   endfunction

   function automatic void add_row(input dir_row_type r);
      dir_tab.insert(dir_tab.size(), r);
   endfunction

   // present one beat, wait for it to be taken, then record what it must answer.
   // called right after a rising edge; start is only lowered when a gap follows,
   // so it never sees two updates in one step
   task automatic send_beat(input spmt_beat_type b, input bit typed,
                            input bit typed_member);
      int          gap;
      int          idle_pct;
      verdict_type v;
      // sender idling per phase: light, then heavy, then none
      if (beats_sent < SPLIT_A) idle_pct = 34;
      else if (beats_sent < SPLIT_B) idle_pct = 77;
      else idle_pct = 0;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start              <= 1'b1;
      req_op             <= b.op;
      req_axis_select    <= b.sel;
      req_axis_size      <= b.size;
      req_axis_step      <= b.step;
      req_pattern_offset <= b.off;
      req_axis_count     <= b.cnt;
      req_query_index    <= b.idx;
      @(posedge clock);
      while (busy) @(posedge clock);
      // taken at this edge
      v.was_query = (b.op == spmt_pkg::OP_QUERY);
      if (b.op == spmt_pkg::OP_LOAD) begin
         v.is_member = 1'b0;
         // loads past the store depth are acknowledged and dropped
         if (b.sel < N_AXES) begin
            size_tbl[b.sel] = b.size;
            step_tbl[b.sel] = b.step;
         end
         load_beats++;
      end else begin
         v.is_member = member_of_pattern(b.off, b.cnt, b.idx);
         query_beats++;
      end
      if (typed) v.is_member = typed_member;
      verdict_q.insert(verdict_q.size(), v);
      // dropped loads do not count toward the run length
      if (!(b.op == spmt_pkg::OP_LOAD && b.sel >= N_AXES)) beats_sent++;
   endtask

   // result checker: every strobe must match the oldest owed answer
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid) begin
         rsp_count++;
         if (rsp_was_query === 1'b1 && rsp_is_member === 1'b1) members_seen++;
         if (verdict_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("tb: stray result %0d (is_member %b was_query %b)",
                        rsp_count, rsp_is_member, rsp_was_query);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_is_member !== want.is_member || rsp_was_query !== want.was_query) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("tb: mismatch %0d: is_member exp %b got %b, was_query exp %b got %b",
                           rsp_count, want.is_member, rsp_is_member,
                           want.was_query, rsp_was_query);
            end
         end
      end
   end

   // watchdog: too long with no beat taken and no result means a hang
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid) quiet = 0;
         else quiet++;
      end
      $display("tb: stalled for %0d cycles with %0d results owed", quiet, verdict_q.size());
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      spmt_beat_type b;
      longint        sz [N_AXES];
      longint        st [N_AXES];
      longint        span;
      longint        off_l;
      longint        idx_l;
      longint        coord;
      int            n;
      int            k;
      int            kind;
      int            d;

      for (int a = 0; a < N_AXES; a++) begin
         size_tbl[a] = '0;
         step_tbl[a] = '0;
      end

      // every input known from time zero
      reset              <= 1'b1;
      start              <= 1'b0;
      req_op             <= spmt_pkg::OP_LOAD;
      req_axis_select    <= '0;
      req_axis_size      <= '0;
      req_axis_step      <= '0;
      req_pattern_offset <= '0;
      req_axis_count     <= '0;
      req_query_index    <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table
      // no axes in use: member exactly when index equals offset
      add_row(mk(spmt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 1, 1));
      add_row(mk(spmt_pkg::OP_QUERY, 0, 0, 0, IDX_MAX_L, 0, IDX_MAX_L, 1, 1));
      add_row(mk(spmt_pkg::OP_QUERY, 0, 0, 0, IDX_MIN_L, 0, IDX_MAX_L, 1, 0));
      add_row(mk(spmt_pkg::OP_QUERY, 0, 0, 0, IDX_MAX_L, 0, IDX_MIN_L, 1, 0));
      // canonical pattern on all six axes, top axis at full scale
      add_row(mk(spmt_pkg::OP_LOAD, 0, 4, 1, 0, 0, 0, 1, 0));
      add_row(mk(spmt_pkg::OP_LOAD, 1, 3, 4, 0, 0, 0, 1, 0));
      add_row(mk(spmt_pkg::OP_LOAD, 2, 2, 12, 0, 0, 0, 1, 0));
      add_row(mk(spmt_pkg::OP_LOAD, 3, 5, 24, 0, 0, 0, 1, 0));
      add_row(mk(spmt_pkg::OP_LOAD, 4, 1, 120, 0, 0, 0, 1, 0));
      add_row(mk(spmt_pkg::OP_LOAD, 5, AXIS_MAX_L, AXIS_MAX_L, 0, 0, 0, 1, 0));
      // loads past the store: acknowledged, store untouched
      add_row(mk(spmt_pkg::OP_LOAD, 6, AXIS_MAX_L, AXIS_MAX_L, IDX_MAX_L, 7,
                 IDX_MIN_L, 1, 0));
      add_row(mk(spmt_pkg::OP_LOAD, 7, 0, 1, IDX_MIN_L, 7, IDX_MAX_L, 1, 0));
      // member, one past, quotient out of range, negative difference
      add_row(mk(spmt_pkg::OP_QUERY, 0, 0, 0, 10, 3, 33, 0, 0));
      add_row(mk(spmt_pkg::OP_QUERY, 0, 0, 0, 10, 3, 34, 0, 0));
      add_row(mk(spmt_pkg::OP_QUERY, 0, 0, 0, 10, 2, 26, 0, 0));
      add_row(mk(spmt_pkg::OP_QUERY, 0, 0, 0, 10, 3, 9, 0, 0));
      // axis count above the store saturates
      add_row(mk(spmt_pkg::OP_QUERY, 7, AXIS_MAX_L, AXIS_MAX_L, IDX_MIN_L, 7,
                 IDX_MIN_L + 2 * AXIS_MAX_L + 97, 0, 0));
      add_row(mk(spmt_pkg::OP_QUERY, 0, 0, 0, IDX_MIN_L, 6, IDX_MAX_L, 0, 0));
      add_row(mk(spmt_pkg::OP_QUERY, 0, 0, 0, IDX_MAX_L, 6, IDX_MIN_L, 0, 0));
      // zero size rejects any quotient
      add_row(mk(spmt_pkg::OP_LOAD, 0, 0, 1, 0, 0, 0, 1, 0));
      add_row(mk(spmt_pkg::OP_QUERY, 0, 0, 0, 0, 1, 0, 1, 0));
      // zero stride on an axis in use rejects
      add_row(mk(spmt_pkg::OP_LOAD, 1, 3, 0, 0, 0, 0, 1, 0));
      add_row(mk(spmt_pkg::OP_QUERY, 0, 0, 0, 0, 2, 5, 1, 0));
      // restore the low axes
      add_row(mk(spmt_pkg::OP_LOAD, 0, 4, 1, 0, 0, 0, 1, 0));
      add_row(mk(spmt_pkg::OP_LOAD, 1, 3, 4, 0, 0, 0, 1, 0));

      foreach (dir_tab[i]) send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].member);

      // random part: every axis now holds a loaded value, so any count is legal
      while (beats_sent < TOTAL_ITEMS) begin
         if ($urandom_range(9) == 0) begin
            // noise: arbitrary beats, dropped loads and stray overwrites among them
            k = $urandom_range(1, 4);
            repeat (k) begin
               b = rand_beat();
               if ($urandom_range(3) == 0) b.sel = spmt_pkg::SEL_W'($urandom_range(N_AXES, 7));
               send_beat(b, 0, 0);
            end
         end else begin
            // fresh canonical pattern on the low axes, then queries against it
            n = $urandom_range(1, N_AXES);
            for (int a = 0; a < n; a++) begin
               case ($urandom_range(9))
                  0:       sz[a] = longint'(rand31());
                  1, 2:    sz[a] = longint'($urandom_range(1, 1000));
                  default: sz[a] = longint'($urandom_range(1, 8));
               endcase
               if (a == 0) begin
                  if ($urandom_range(3) == 0) st[a] = longint'($urandom_range(1, 1 << 20));
                  else st[a] = longint'($urandom_range(1, 4));
               end else begin
                  // dense or with a small slack above the axis below
                  st[a] = st[a-1] * sz[a-1];
                  if ($urandom_range(1)) st[a] += longint'($urandom_range(1, 16));
               end
               if ($urandom_range(19) == 0) st[a] = longint'(rand31());
               if (st[a] > AXIS_MAX_L || st[a] < 0)
                  st[a] = AXIS_MAX_L - longint'($urandom_range(15));
               if (st[a] == 0) st[a] = 1;
               b      = rand_beat();
               b.op   = spmt_pkg::OP_LOAD;
               b.sel  = spmt_pkg::SEL_W'(a);
               b.size = spmt_pkg::AXIS_W'(sz[a]);
               b.step = spmt_pkg::AXIS_W'(st[a]);
               send_beat(b, 0, 0);
            end

            span = 0;
            for (int a = 0; a < n; a++)
               if (sz[a] > 0) span += (sz[a] - 1) * st[a];

            case ($urandom_range(4))
               0: off_l = longint'($signed(rand48()));
               1: begin
                  if (span >= 0 && span < (64'sd1 <<< 46)) off_l = IDX_MAX_L - span;
                  else off_l = longint'($signed(rand48()));
               end
               2:       off_l = IDX_MIN_L;
               default: off_l = longint'($signed(rand48())) >>> 8;
            endcase

            k = $urandom_range(3, 8);
            repeat (k) begin
               // a point of the pattern, corners now and then
               idx_l = off_l;
               for (int a = 0; a < n; a++) begin
                  if (sz[a] > 0) begin
                     if ($urandom_range(3) == 0) coord = sz[a] - 1;
                     else coord = longint'($urandom) % sz[a];
                     idx_l += coord * st[a];
                  end
               end
               kind = $urandom_range(19);
               if (kind >= 9 && kind <= 11) begin
                  // just off a member
                  d = $urandom_range(1, 3);
                  if ($urandom_range(1)) idx_l += d;
                  else idx_l -= d;
               end else if (kind == 12 || kind == 13) begin
                  // below the offset
                  idx_l = off_l - longint'($urandom_range(1, 1000));
               end else if (kind == 14 || kind == 15) begin
                  // one step past the top axis
                  idx_l += st[n-1] * sz[n-1];
               end else if (kind >= 16) begin
                  idx_l = longint'($signed(rand48()));
               end
               b     = rand_beat();
               b.op  = spmt_pkg::OP_QUERY;
               b.off = spmt_pkg::IDX_W'(off_l);
               b.idx = spmt_pkg::IDX_W'(idx_l);
               if ($urandom_range(4) == 0) b.cnt = spmt_pkg::CNT_W'($urandom_range(7));
               else b.cnt = spmt_pkg::CNT_W'(n);
               send_beat(b, 0, 0);
            end
         end
      end
      start <= 1'b0;

      // drain what is owed, then a short tail to catch strays
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("tb: %0d load beats and %0d query beats sent, %0d results checked",
               load_beats, query_beats, rsp_count);
      $display("tb: %0d queries found members, %0d mismatches", members_seen, mismatches);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/spmt_pkg.sv
rtl/spmt_div.sv
rtl/spmt_dp.sv
rtl/spmt_ctrl.sv
rtl/strided_pattern_membership_test_top.sv
rtl/spmt_chk.sv
tb/sv/tb.sv
